@@ sv/scrp_pkg.sv @@
package scrp_pkg;

  typedef enum logic [2:0] {
    EV_MORE   = 3'd0,
    EV_METHOD = 3'd1,
    EV_ADDR   = 3'd2,
    EV_NAME   = 3'd3,
    EV_DONE   = 3'd4,
    EV_ERROR  = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_VERSION  = 4'd1,
    ERR_METHOD   = 4'd2,
    ERR_COMMAND  = 4'd3,
    ERR_USER_ID  = 4'd4,
    ERR_HEADER   = 4'd5,
    ERR_ADDR_TYP = 4'd6,
    ERR_TOO_LONG = 4'd7,
    ERR_TRAILING = 4'd8
  } error_e;

  typedef enum logic [1:0] {
    AK_IPV4 = 2'd0,
    AK_IPV6 = 2'd1,
    AK_NAME = 2'd2
  } addr_kind_e;

  typedef enum logic [2:0] {
    ST_PARSING = 3'b001,
    ST_DONE    = 3'b010,
    ST_FAILED  = 3'b100
  } status_e;

  // socks5 address type bytes
  localparam logic [7:0] ATYP_IPV4 = 8'd1;
  localparam logic [7:0] ATYP_NAME = 8'd3;
  localparam logic [7:0] ATYP_IPV6 = 8'd4;

  localparam logic [7:0] VER_SOCKS4  = 8'd4;
  localparam logic [7:0] VER_SOCKS5  = 8'd5;
  localparam logic [7:0] CMD_CONNECT = 8'd1;
  localparam logic [7:0] METHOD_CNT  = 8'd1;

  localparam logic [8:0] NAME_LEN_MAX = 9'd511;

  typedef struct packed {
    logic       proto_v5;
    addr_kind_e addr_kind;
    logic [8:0] name_len;
    logic       s4a_flag;
    logic [15:0] port;
    status_e    status;
    error_e     last_err;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    proto_v5:  1'b0,
    addr_kind: AK_IPV4,
    name_len:  9'd0,
    s4a_flag:  1'b0,
    port:      16'd0,
    status:    ST_PARSING,
    last_err:  ERR_NONE
  };

  typedef struct packed {
    event_e     ev;
    logic [7:0] out_byte;
    logic       protocol;
    addr_kind_e kind;
    logic [15:0] port;
    logic [8:0] name_len;
    error_e     err;
  } parse_result_t;

endpackage

@@ sv/scrp_step.sv @@
module scrp_step import scrp_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 512,
  parameter int CntW = $clog2(MAX_REQUEST_BYTES)
) (
  input  logic          start_i,
  input  logic [7:0]    byte_i,
  input  parse_state_t  st_i,
  input  logic [CntW-1:0] cnt_i,
  output parse_state_t  st_o,
  output logic [CntW-1:0] cnt_o,
  output parse_result_t res_o
);

  localparam int CmpW = 11;
  localparam logic [CmpW-1:0] MaxBytes = CmpW'(MAX_REQUEST_BYTES);

  parse_state_t    st;
  logic [CntW-1:0] cnt;
  logic [CmpW-1:0] p;
  logic [CmpW-1:0] q;
  logic [CmpW-1:0] nl;
  event_e          ev;
  logic [7:0]      ob;
  addr_kind_e      kind;
  logic [8:0]      nlen;
  error_e          err;
  logic            complete;

  always_comb begin
    st = st_i;
    cnt = cnt_i;
    if (start_i) begin
      st = STATE_CLEAR;
      cnt = '0;
    end
    p = CmpW'(cnt);
    q = p - 11'd8;
    nl = CmpW'(st.name_len);
    ev = EV_MORE;
    ob = 8'd0;
    kind = AK_IPV4;
    nlen = 9'd0;
    err = ERR_NONE;
    complete = 1'b0;

    unique case (st.status)
      ST_DONE: begin
        st.status = ST_FAILED;
        st.last_err = ERR_TRAILING;
        err = ERR_TRAILING;
      end
      ST_PARSING: begin
        if (p == 11'd0) begin
          if (byte_i == VER_SOCKS4) st.proto_v5 = 1'b0;
          else if (byte_i == VER_SOCKS5) st.proto_v5 = 1'b1;
          else err = ERR_VERSION;
        end else if (!st.proto_v5) begin
          // socks4 / 4a
          priority if (p == 11'd1) begin
            if (byte_i != CMD_CONNECT) err = ERR_COMMAND;
          end else if (p <= 11'd3) begin
            st.port = {st.port[7:0], byte_i};
          end else if (p <= 11'd7) begin
            ev = EV_ADDR;
            ob = byte_i;
            if (p == 11'd4) st.s4a_flag = (byte_i == 8'd0);
            else if (p < 11'd7) st.s4a_flag = st.s4a_flag && (byte_i == 8'd0);
            else st.s4a_flag = st.s4a_flag && (byte_i != 8'd0);
          end else if (p == 11'd8) begin
            if (byte_i != 8'd0) err = ERR_USER_ID;
            else if (!st.s4a_flag) complete = 1'b1;
          end else if (byte_i == 8'd0) begin
            complete = 1'b1;
            if (st.name_len != 9'd0) begin
              kind = AK_NAME;
              nlen = st.name_len;
            end
          end else begin
            ev = EV_NAME;
            ob = byte_i;
            if (st.name_len < NAME_LEN_MAX) st.name_len = st.name_len + 9'd1;
          end
        end else begin
          // socks5 greeting, header, address, port
          priority if (p == 11'd1) begin
            if (byte_i != METHOD_CNT) err = ERR_METHOD;
          end else if (p == 11'd2) begin
            if (byte_i != 8'd0) err = ERR_METHOD;
            else ev = EV_METHOD;
          end else if (p == 11'd3) begin
            if (byte_i != VER_SOCKS5) err = ERR_VERSION;
          end else if (p == 11'd4) begin
            if (byte_i != CMD_CONNECT) err = ERR_COMMAND;
          end else if (p == 11'd5) begin
            if (byte_i != 8'd0) err = ERR_HEADER;
          end else if (p == 11'd6) begin
            if (byte_i == ATYP_IPV4) st.addr_kind = AK_IPV4;
            else if (byte_i == ATYP_IPV6) st.addr_kind = AK_IPV6;
            else if (byte_i == ATYP_NAME) st.addr_kind = AK_NAME;
            else err = ERR_ADDR_TYP;
          end else if (st.addr_kind == AK_IPV4) begin
            if (p <= 11'd10) begin
              ev = EV_ADDR;
              ob = byte_i;
            end else begin
              st.port = {st.port[7:0], byte_i};
              if (p >= 11'd12) complete = 1'b1;
            end
          end else if (st.addr_kind == AK_IPV6) begin
            if (p <= 11'd22) begin
              ev = EV_ADDR;
              ob = byte_i;
            end else begin
              st.port = {st.port[7:0], byte_i};
              if (p >= 11'd24) begin
                complete = 1'b1;
                kind = AK_IPV6;
              end
            end
          end else if (p == 11'd7) begin
            st.name_len = {1'b0, byte_i};
          end else if (q < nl) begin
            ev = EV_NAME;
            ob = byte_i;
          end else begin
            st.port = {st.port[7:0], byte_i};
            if (q >= nl + 11'd1) begin
              complete = 1'b1;
              kind = AK_NAME;
              nlen = st.name_len;
            end
          end
        end

        if (err != ERR_NONE) begin
          st.status = ST_FAILED;
          st.last_err = err;
        end else if (complete) begin
          st.status = ST_DONE;
          ev = EV_DONE;
        end else begin
          cnt = cnt + CntW'(1);
          if (p + 11'd1 >= MaxBytes) begin
            err = ERR_TOO_LONG;
            st.status = ST_FAILED;
            st.last_err = ERR_TOO_LONG;
          end
        end
      end
      default: begin
        err = st.last_err;
      end
    endcase

    st_o = st;
    cnt_o = cnt;
    res_o.ev = ev;
    res_o.out_byte = ob;
    res_o.protocol = st.proto_v5;
    res_o.kind = kind;
    res_o.port = st.port;
    res_o.name_len = nlen;
    res_o.err = err;
    if (err != ERR_NONE) begin
      res_o.ev = EV_ERROR;
      res_o.out_byte = 8'd0;
      res_o.kind = AK_IPV4;
      res_o.port = 16'd0;
      res_o.name_len = 9'd0;
    end else if (ev != EV_DONE) begin
      res_o.kind = AK_IPV4;
      res_o.port = 16'd0;
      res_o.name_len = 9'd0;
    end
  end

endmodule

@@ sv/socks_connect_request_parser_top.sv @@
// channel   direction  handshake                 payload
// in        to block   in_valid_i / in_stall_o   start_req_i, data_byte_i
// out       from block out_valid_o / out_stall_i event_res_o, out_byte_o, protocol_o,
//                                                address_kind_o, dest_port_o,
//                                                name_length_o, error_code_o
//
// one word in, one result word out; a word moves through an input register and
// is then parsed into the result register; a new word is taken every cycle
// while the output does not stall
// the parser state advances when a word leaves the input register
// a stalled output holds the result and backs up the input register only
// rst_ni clears the parser state and empties both registers
module socks_connect_request_parser_top import scrp_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  out_byte_o,
  output logic        protocol_o,
  output logic [1:0]  address_kind_o,
  output logic [15:0] dest_port_o,
  output logic [8:0]  name_length_o,
  output logic [3:0]  error_code_o
);

  localparam int CntW = $clog2(MAX_REQUEST_BYTES);

  // input register
  logic       in_vld_q;
  logic       in_start_q;
  logic [7:0] in_byte_q;

  // parser state
  parse_state_t    st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // result register
  logic          out_vld_q;
  parse_result_t res_q, res_d;

  logic advance;
  logic in_take;

  // a word is parsed when the result register is free or being drained
  assign advance = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take = in_valid_i && !in_stall_o;

  scrp_step #(
    .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
    .CntW(CntW)
  ) u_step (
    .start_i(in_start_q),
    .byte_i (in_byte_q),
    .st_i   (st_q),
    .cnt_i  (cnt_q),
    .st_o   (st_d),
    .cnt_o  (cnt_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q <= STATE_CLEAR;
      cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance) begin
        st_q <= st_d;
        cnt_q <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_start_q <= start_req_i;
      in_byte_q <= data_byte_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o    = out_vld_q;
  assign event_res_o    = res_q.ev;
  assign out_byte_o     = res_q.out_byte;
  assign protocol_o     = res_q.protocol;
  assign address_kind_o = res_q.kind;
  assign dest_port_o    = res_q.port;
  assign name_length_o  = res_q.name_len;
  assign error_code_o   = res_q.err;

endmodule

@@ bench/socks_parse_checker.sv @@
module socks_parse_checker import scrp_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        start_req_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  event_res_i,
  input  logic [7:0]  out_byte_i,
  input  logic        protocol_i,
  input  logic [1:0]  address_kind_i,
  input  logic [15:0] dest_port_i,
  input  logic [8:0]  name_length_i,
  input  logic [3:0]  error_code_i,
  output int          mismatch_count_o,
  output int          words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as seen from the client byte stream
  logic [9:0]  byte_count = '0;
  logic        proto_v5 = 1'b0;
  logic [7:0]  addr_type = '0;
  logic [8:0]  name_count = '0;
  logic        s4a_flag = 1'b0;
  logic [15:0] port_acc = '0;
  status_e     status = ST_PARSING;
  error_e      last_err = ERR_NONE;

  parse_result_t parse_result_q[$];
  parse_result_t want;

  function automatic void clear_parser();
    byte_count = '0;
    proto_v5   = 1'b0;
    addr_type  = '0;
    name_count = '0;
    s4a_flag   = 1'b0;
    port_acc   = '0;
    status     = ST_PARSING;
    last_err   = ERR_NONE;
  endfunction

  function automatic parse_result_t parse_client_byte(logic start, logic [7:0] b);
    parse_result_t r;
    event_e     ev;
    logic [7:0] ob;
    addr_kind_e kind;
    logic [15:0] port;
    logic [8:0] nlen;
    error_e     err;
    logic       complete;
    int         p;
    int         q;
    if (start) clear_parser();
    ev = EV_MORE;
    ob = '0;
    kind = AK_IPV4;
    port = '0;
    nlen = '0;
    err = ERR_NONE;
    complete = 1'b0;
    if (status == ST_DONE) begin
      status = ST_FAILED;
      last_err = ERR_TRAILING;
      err = ERR_TRAILING;
    end else if (status != ST_PARSING) begin
      err = last_err;
    end else begin
      p = int'(byte_count);
      if (p == 0) begin
        if (b == VER_SOCKS4) proto_v5 = 1'b0;
        else if (b == VER_SOCKS5) proto_v5 = 1'b1;
        else err = ERR_VERSION;
      end else if (!proto_v5) begin
        if (p == 1) begin
          if (b != CMD_CONNECT) err = ERR_COMMAND;
        end else if (p <= 3) begin
          port_acc = {port_acc[7:0], b};
        end else if (p <= 7) begin
          ev = EV_ADDR;
          ob = b;
          if (p == 4) s4a_flag = (b == 8'd0);
          else if (p < 7) s4a_flag = s4a_flag && (b == 8'd0);
          else s4a_flag = s4a_flag && (b != 8'd0);
        end else if (p == 8) begin
          if (b != 8'd0) err = ERR_USER_ID;
          else if (!s4a_flag) complete = 1'b1;
        end else if (b == 8'd0) begin
          complete = 1'b1;
          if (name_count != 0) begin
            kind = AK_NAME;
            nlen = name_count;
          end
        end else begin
          ev = EV_NAME;
          ob = b;
          if (name_count < NAME_LEN_MAX) name_count = name_count + 1'b1;
        end
      end else begin
        if (p == 1) begin
          if (b != METHOD_CNT) err = ERR_METHOD;
        end else if (p == 2) begin
          if (b != 8'd0) err = ERR_METHOD;
          else ev = EV_METHOD;
        end else if (p == 3) begin
          if (b != VER_SOCKS5) err = ERR_VERSION;
        end else if (p == 4) begin
          if (b != CMD_CONNECT) err = ERR_COMMAND;
        end else if (p == 5) begin
          if (b != 8'd0) err = ERR_HEADER;
        end else if (p == 6) begin
          if (b == ATYP_IPV4 || b == ATYP_NAME || b == ATYP_IPV6) addr_type = b;
          else err = ERR_ADDR_TYP;
        end else if (addr_type == ATYP_IPV4) begin
          if (p <= 10) begin
            ev = EV_ADDR;
            ob = b;
          end else begin
            port_acc = {port_acc[7:0], b};
            if (p >= 12) complete = 1'b1;
          end
        end else if (addr_type == ATYP_IPV6) begin
          if (p <= 22) begin
            ev = EV_ADDR;
            ob = b;
          end else begin
            port_acc = {port_acc[7:0], b};
            if (p >= 24) begin
              complete = 1'b1;
              kind = AK_IPV6;
            end
          end
        end else if (p == 7) begin
          name_count = {1'b0, b};
        end else begin
          q = p - 8;
          if (q < int'(name_count)) begin
            ev = EV_NAME;
            ob = b;
          end else begin
            port_acc = {port_acc[7:0], b};
            if (q >= int'(name_count) + 1) begin
              complete = 1'b1;
              kind = AK_NAME;
              nlen = name_count;
            end
          end
        end
      end

      if (err != ERR_NONE) begin
        status = ST_FAILED;
        last_err = err;
      end else if (complete) begin
        status = ST_DONE;
        ev = EV_DONE;
        port = port_acc;
      end else begin
        byte_count = byte_count + 1'b1;
        if (p + 1 >= MAX_REQUEST_BYTES) begin
          err = ERR_TOO_LONG;
          status = ST_FAILED;
          last_err = ERR_TOO_LONG;
        end
      end
    end

    if (err != ERR_NONE) begin
      ev = EV_ERROR;
      ob = '0;
      kind = AK_IPV4;
      port = '0;
      nlen = '0;
    end else if (ev != EV_DONE) begin
      kind = AK_IPV4;
      port = '0;
      nlen = '0;
    end
    r.ev = ev;
    r.out_byte = ob;
    r.protocol = proto_v5;
    r.kind = kind;
    r.port = port;
    r.name_len = nlen;
    r.err = err;
    return r;
  endfunction

  function automatic void check_field(string field, logic [15:0] exp_val, logic [15:0] got);
    if (got !== exp_val) begin
      $display("%0t: %s expected %0h got %0h", $time, field, exp_val, got);
      mismatch_count_o++;
    end
  endfunction

  // push first so any latency works, then match the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      parse_result_q.delete();
      words_pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        parse_result_q.push_back(parse_client_byte(start_req_i, data_byte_i));
      if (out_valid_i && !out_stall_i) begin
        if (parse_result_q.size() == 0) begin
          $display("%0t: result word expected none got event %0h", $time, event_res_i);
          mismatch_count_o++;
        end else begin
          want = parse_result_q.pop_front();
          check_field("event_res", 16'(want.ev), 16'(event_res_i));
          check_field("out_byte", 16'(want.out_byte), 16'(out_byte_i));
          check_field("protocol", 16'(want.protocol), 16'(protocol_i));
          check_field("address_kind", 16'(want.kind), 16'(address_kind_i));
          check_field("dest_port", want.port, dest_port_i);
          check_field("name_length", 16'(want.name_len), 16'(name_length_i));
          check_field("error_code", 16'(want.err), 16'(error_code_i));
        end
      end
      words_pending_o = parse_result_q.size();
    end
  end

endmodule

@@ bench/socks_connect_request_parser_top_test.sv @@
module socks_connect_request_parser_top_test import scrp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int MAX_REQ      = 512;
  localparam int RESET_CYCLES = 8;
  localparam int WORD_TARGET  = 1700;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int IDLE_PCT     = 11;

  // fixed byte values of the handshakes
  localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
  localparam logic [7:0] RSV_BYTE       = 8'h00;
  localparam logic [7:0] NUL_BYTE       = 8'h00;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        start_req_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [7:0]  out_byte_o;
  logic        protocol_o;
  logic [1:0]  address_kind_o;
  logic [15:0] dest_port_o;
  logic [8:0]  name_length_o;
  logic [3:0]  error_code_o;

  int mismatches;
  int words_pending;
  int words_sent = 0;
  int cycle_count = 0;
  // no idling on either side while set
  bit steady = 1'b0;

  // bytes of the request being built, sent in order
  word_t seq_q[$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  socks_connect_request_parser_top #(.MAX_REQUEST_BYTES(MAX_REQ)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_req_i    (start_req_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .out_byte_o     (out_byte_o),
    .protocol_o     (protocol_o),
    .address_kind_o (address_kind_o),
    .dest_port_o    (dest_port_o),
    .name_length_o  (name_length_o),
    .error_code_o   (error_code_o)
  );

  // watches both channels, predicts every result word and compares
  socks_parse_checker #(.MAX_REQUEST_BYTES(MAX_REQ)) u_parse_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .start_req_i      (start_req_i),
    .data_byte_i      (data_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_i      (event_res_o),
    .out_byte_i       (out_byte_o),
    .protocol_i       (protocol_o),
    .address_kind_i   (address_kind_o),
    .dest_port_i      (dest_port_o),
    .name_length_i    (name_length_o),
    .error_code_i     (error_code_o),
    .mismatch_count_o (mismatches),
    .words_pending_o  (words_pending)
  );

  // receiver side: random stalls, none during the steady stretch
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("socks_connect_request_parser_top_test NOT OK");
      $finish;
    end
  end

  function automatic void queue_word(logic start, logic [7:0] data);
    word_t w;
    w.start = start;
    w.data = data;
    seq_q.push_back(w);
  endfunction

  // socks4 connect; an address of 0.0.0.x with x nonzero gets a socks4a name
  function automatic void add_socks4(logic [15:0] port, logic [31:0] ip, int name_len);
    queue_word(1'b1, VER_SOCKS4);
    queue_word(1'b0, CMD_CONNECT);
    queue_word(1'b0, port[15:8]);
    queue_word(1'b0, port[7:0]);
    queue_word(1'b0, ip[31:24]);
    queue_word(1'b0, ip[23:16]);
    queue_word(1'b0, ip[15:8]);
    queue_word(1'b0, ip[7:0]);
    queue_word(1'b0, NUL_BYTE);  // empty user id
    if (ip[31:8] == 24'h0 && ip[7:0] != 8'h00) begin
      for (int i = 0; i < name_len; i++) queue_word(1'b0, 8'($urandom_range(255, 1)));
      queue_word(1'b0, NUL_BYTE);
    end
  endfunction

  // socks5 greeting plus connect; an unknown address type stops after the type byte
  function automatic void add_socks5(logic [7:0] atyp, logic [15:0] port, int name_len);
    queue_word(1'b1, VER_SOCKS5);
    queue_word(1'b0, METHOD_CNT);
    queue_word(1'b0, METHOD_NO_AUTH);
    queue_word(1'b0, VER_SOCKS5);
    queue_word(1'b0, CMD_CONNECT);
    queue_word(1'b0, RSV_BYTE);
    queue_word(1'b0, atyp);
    if (atyp == ATYP_IPV4) begin
      repeat (4) queue_word(1'b0, 8'($urandom));
    end else if (atyp == ATYP_IPV6) begin
      repeat (16) queue_word(1'b0, 8'($urandom));
    end else if (atyp == ATYP_NAME) begin
      queue_word(1'b0, 8'(name_len));
      // any byte value may sit inside a length-prefixed name
      repeat (name_len) queue_word(1'b0, 8'($urandom));
    end else begin
      return;
    end
    queue_word(1'b0, port[15:8]);
    queue_word(1'b0, port[7:0]);
  endfunction

  // sender side: random idle cycles, payload held while stalled
  task automatic send_word(word_t w);
    logic stalled;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_req_i <= w.start;
    data_byte_i <= w.data;
    // stall is settled at the falling edge and holds until the next rising one
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    words_sent++;
  endtask

  task automatic send_sequence();
    while (seq_q.size() > 0) send_word(seq_q.pop_front());
  endtask

  function automatic logic [15:0] pick_port();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  initial begin
    logic [31:0] ip;
    logic [7:0]  atyp;
    int          pick;
    int          mut;
    int          idx;
    int          keep;
    word_t       w;
    bit          long_sent;
    long_sent = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown version, socks4 with extreme port then a trailing byte,
    // socks4a with an empty name, socks5 with an unknown address type
    queue_word(1'b1, 8'h00);
    add_socks4(16'hFFFF, 32'h0A000001, 0);
    queue_word(1'b0, 8'hFF);
    add_socks4(16'h0000, 32'h000000FF, 0);
    add_socks5(8'h02, 16'h1234, 0);
    send_sequence();

    // random: mostly well-formed requests with random content, some broken
    while (words_sent < WORD_TARGET) begin
      steady = (words_sent >= 700 && words_sent < 1000);
      if (!long_sent && words_sent >= 400) begin
        // socks4a name that runs past the request size limit
        long_sent = 1'b1;
        add_socks4(pick_port(), {24'h0, 8'($urandom_range(255, 1))}, MAX_REQ + 8);
        send_sequence();
        continue;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        case ($urandom_range(3))
          0: ip = {24'h0, 8'($urandom_range(255, 1))};
          1: ip = 32'h0;
          2: ip = {16'h0, 8'($urandom_range(1)), 8'($urandom)};
          default: ip = $urandom;
        endcase
        add_socks4(pick_port(), ip, $urandom_range(12));
      end else if (pick < 35) begin
        add_socks4(pick_port(), {24'h0, 8'($urandom_range(255, 1))},
                   ($urandom_range(15) == 0) ? 100 : $urandom_range(12));
      end else if (pick < 50) begin
        add_socks5(ATYP_IPV4, pick_port(), 0);
      end else if (pick < 62) begin
        add_socks5(ATYP_IPV6, pick_port(), 0);
      end else if (pick < 80) begin
        add_socks5(ATYP_NAME, pick_port(),
                   ($urandom_range(15) == 0) ? 255 : $urandom_range(12));
      end else if (pick < 88) begin
        do atyp = 8'($urandom);
        while (atyp == ATYP_IPV4 || atyp == ATYP_NAME || atyp == ATYP_IPV6);
        add_socks5(atyp, pick_port(), 0);
      end else begin
        // noise, sometimes continuing whatever state the parser is in
        queue_word(1'($urandom_range(1)), 8'($urandom));
        repeat ($urandom_range(5)) queue_word(1'b0, 8'($urandom));
      end

      // damage some requests: one bad byte, cut short, or bytes past the end
      mut = $urandom_range(99);
      if (mut < 12) begin
        idx = $urandom_range(seq_q.size() - 1);
        w = seq_q[idx];
        w.data = 8'($urandom);
        seq_q[idx] = w;
      end else if (mut < 22 && seq_q.size() > 1) begin
        keep = $urandom_range(seq_q.size() - 1, 1);
        while (seq_q.size() > keep) void'(seq_q.pop_back());
      end else if (mut < 32) begin
        repeat ($urandom_range(3, 1)) queue_word(1'b0, 8'($urandom));
      end
      send_sequence();
    end

    in_valid_i <= 1'b0;
    steady = 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("socks_connect_request_parser_top_test OK");
    end else begin
      $display("socks_connect_request_parser_top_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/scrp_pkg.sv
sv/scrp_step.sv
sv/socks_connect_request_parser_top.sv
bench/socks_parse_checker.sv
bench/socks_connect_request_parser_top_test.sv
